### sv/sbpt_pkg.sv
// ----------------------------------------------------------------------------
// sbpt_pkg
// Shared types and constants for the serial byte pattern trigger.
// ----------------------------------------------------------------------------
package sbpt_pkg;

    localparam int BYTE_W       = 8;
    localparam int PAT_BYTES    = 16;   // bytes held by the two pattern registers
    localparam int PAT_IDX_W    = 4;    // index into the pattern bytes
    localparam int LEN_W        = 5;    // pattern_length register width
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int OP_W         = 2;

    // operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_BYTE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    typedef struct packed {
        logic armed;
        logic trigger;
    } result_t;

endpackage

### sv/sbpt_match_core.sv
// ----------------------------------------------------------------------------
// sbpt_match_core
// Pattern registers, byte window and armed flag; computes the result of one
// input transfer in the cycle it is accepted.
// ----------------------------------------------------------------------------
module sbpt_match_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_fire,
    input  logic [sbpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // accepted input transfer
    input  logic                              in_fire,
    input  logic [sbpt_pkg::OP_W-1:0]         in_op,
    input  logic [sbpt_pkg::BYTE_W-1:0]       in_byte,
    // result of the transfer, valid with in_fire
    output sbpt_pkg::result_t                 res
);

    logic [sbpt_pkg::CFG_DATA_W-1:0] pat_low_reg, pat_low_next;
    logic [sbpt_pkg::CFG_DATA_W-1:0] pat_high_reg, pat_high_next;
    logic [sbpt_pkg::LEN_W-1:0]      pat_len_reg, pat_len_next;
    logic [MAX_PATTERN-1:0][sbpt_pkg::BYTE_W-1:0] window_reg, window_next;
    logic                            armed_reg, armed_next;

    logic [sbpt_pkg::LEN_W-1:0]      len_eff;
    logic [sbpt_pkg::PAT_BYTES-1:0][sbpt_pkg::BYTE_W-1:0] pat_bytes;
    logic [MAX_PATTERN-1:0][sbpt_pkg::BYTE_W-1:0] win_shift;
    logic [MAX_PATTERN-1:0]          lane_ok;
    logic [sbpt_pkg::PAT_IDX_W-1:0]  pat_idx [MAX_PATTERN];
    logic                            match;
    logic                            cfg_hit;
    logic                            trig;

    assign len_eff = (pat_len_reg > sbpt_pkg::LEN_W'(MAX_PATTERN))
                   ? sbpt_pkg::LEN_W'(MAX_PATTERN) : pat_len_reg;

    assign pat_bytes = {pat_high_reg, pat_low_reg};

    // window as it looks after the new byte shifts in; entry 0 is newest
    always_comb begin
        win_shift[0] = in_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_shift[j] = window_reg[j-1];
        end
    end

    // window entry j is compared with pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pat_idx[j] = sbpt_pkg::PAT_IDX_W'(len_eff - sbpt_pkg::LEN_W'(j + 1));
            lane_ok[j] = (sbpt_pkg::LEN_W'(j) >= len_eff)
                       || (win_shift[j] == pat_bytes[pat_idx[j]]);
        end
    end

    assign match = (len_eff != '0) && (&lane_ok);

    assign cfg_hit = cfg_fire && (cfg_index == sbpt_pkg::CFG_PAT_LOW
                               || cfg_index == sbpt_pkg::CFG_PAT_HIGH
                               || cfg_index == sbpt_pkg::CFG_PAT_LEN);

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        pat_len_next  = pat_len_reg;
        window_next   = window_reg;
        armed_next    = armed_reg;
        trig          = 1'b0;
        if (cfg_hit) begin
            unique case (cfg_index)
                sbpt_pkg::CFG_PAT_LOW:  pat_low_next  = cfg_data;
                sbpt_pkg::CFG_PAT_HIGH: pat_high_next = cfg_data;
                sbpt_pkg::CFG_PAT_LEN:  pat_len_next  = cfg_data[sbpt_pkg::LEN_W-1:0];
                default: ;
            endcase
            window_next = '0;
        end else if (in_fire) begin
            case (in_op)
                sbpt_pkg::OP_BYTE: begin
                    if (armed_reg) begin
                        window_next = win_shift;
                        if (match) begin
                            trig       = 1'b1;
                            armed_next = 1'b0;
                        end
                    end
                end
                sbpt_pkg::OP_ARM: begin
                    if (len_eff != '0) begin
                        armed_next = 1'b1;
                    end
                end
                sbpt_pkg::OP_DISARM: armed_next = 1'b0;
                default: ;
            endcase
        end
    end

    assign res.trigger = trig;
    assign res.armed   = armed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            window_reg   <= '0;
            armed_reg    <= 1'b0;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            pat_len_reg  <= pat_len_next;
            window_reg   <= window_next;
            armed_reg    <= armed_next;
        end
    end

    a_trig_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !cfg_fire && res.trigger |=> !armed_reg)
        else $error("armed flag still set after a trigger");

    a_arm_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(armed_reg) |-> $past(in_fire && in_op == sbpt_pkg::OP_ARM && len_eff != '0))
        else $error("armed without a valid arm request");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> window_reg == '0)
        else $error("window not cleared by a pattern write");

    a_idle_window: assert property (@(posedge aclk) disable iff (!aresetn)
        !armed_reg && !cfg_fire |=> $stable(window_reg))
        else $error("window moved while disarmed");

endmodule

### sv/sbpt_out_buffer.sv
// ----------------------------------------------------------------------------
// sbpt_out_buffer
// Two-entry output register with skid stage for the result stream.
// ----------------------------------------------------------------------------
module sbpt_out_buffer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  sbpt_pkg::result_t in_res,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sbpt_pkg::result_t out_res
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    sbpt_pkg::result_t out_reg;
    sbpt_pkg::result_t skid_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= in_res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_reg))
        else $error("skid entry lost during stall");

endmodule

### sv/serial_byte_pattern_trigger_unit.sv
// ----------------------------------------------------------------------------
// serial_byte_pattern_trigger_unit
// Arms on request and fires a one-shot trigger when the last received bytes
// equal a programmed pattern of up to MAX_PATTERN bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per item; s_tuser carries the operation (byte,
//   arm, disarm), s_tdata the received byte. Every transfer produces exactly
//   one m_ transfer: m_tdata bit 0 is the trigger, bit 1 the armed flag
//   after the item.
//   cfg channel: index 0/1 load pattern bytes 0-7 and 8-15 (oldest byte in
//   the low bits), index 2 the pattern length. A write to any of them clears
//   the byte window. Write only while no items are in flight. cfg_ready is
//   always high.
//   Output: each result is registered in the output buffer before it reaches m_.
//   Throughput: one item per cycle while s_tready is high; the window shift and all byte compares
//   finish in the cycle of the transfer.
//   Reset (aresetn low, synchronous): pattern and length cleared, window
//   zeroed, disarmed, output empty.
//   Stall: a result register plus one skid entry absorb a stalled m_ side;
//   s_tready drops only when both hold results.
// ----------------------------------------------------------------------------
module serial_byte_pattern_trigger_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                        s_tuser,   // [1:0] op
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] trigger, [1] armed, [7:2] zero
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic              in_fire;
    logic              cfg_fire;
    sbpt_pkg::result_t core_res;
    sbpt_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;

    sbpt_match_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .res       (core_res)
    );

    sbpt_out_buffer u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_res    (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.armed, out_res.trigger};

endmodule

### tb/serial_byte_pattern_trigger_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_byte_pattern_trigger_unit_tb
// Self-checking bench for the byte pattern trigger. A short stimulus table
// covers reset state, refused arm, reserved op, short and full-length
// patterns, the length clamp and an ignored register index. Random phases
// then reprogram the pattern and feed mostly complete pattern runs with
// paced bursts and a stalling receiver. Every result is compared against a
// cycle-free model of the window and armed flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module serial_byte_pattern_trigger_unit_tb;

    localparam int N_PHASES     = 16;
    localparam int PHASE_ITEMS  = 55;
    localparam int HOLD_CYCLES  = 400;
    localparam int WD_LIMIT     = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 30;

    localparam logic [sbpt_pkg::OP_W-1:0]      OP_RESERVED = 2'd3;
    localparam logic [sbpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct {
        bit                chk;
        sbpt_pkg::result_t typed;
    } typed_note_t;

    typedef struct {
        sbpt_pkg::result_t predicted;
        bit                chk;
        sbpt_pkg::result_t typed;
    } trig_expect_t;

    typedef struct {
        logic [sbpt_pkg::CFG_IDX_W-1:0]  idx;
        logic [sbpt_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [sbpt_pkg::OP_W-1:0]       op;
        logic [sbpt_pkg::CFG_IDX_W-1:0]  idx;
        logic [sbpt_pkg::CFG_DATA_W-1:0] val;
        bit                              chk;
        sbpt_pkg::result_t               typed;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;    // [7:0] rx_byte
    logic [1:0]                       s_tuser;    // [1:0] op
    logic                             m_tvalid;
    logic                             m_tready;
    logic [7:0]                       m_tdata;    // [0] trigger, [1] armed, [7:2] zero
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sbpt_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [sbpt_pkg::CFG_DATA_W-1:0]  cfg_data;

    serial_byte_pattern_trigger_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // trigger model state
    logic [7:0]                      win_m [sbpt_pkg::PAT_BYTES];
    logic                            armed_m;
    logic [sbpt_pkg::CFG_DATA_W-1:0] pat_low_m;
    logic [sbpt_pkg::CFG_DATA_W-1:0] pat_high_m;
    logic [sbpt_pkg::LEN_W-1:0]      pat_len_m;

    trig_expect_t pending_results[$];
    typed_note_t  typed_notes[$];
    reg_write_t   reg_writes[$];
    stim_row_t    stim_rows[$];

    int  errors      = 0;
    int  n_items     = 0;
    int  n_triggers  = 0;
    int  n_writes    = 0;
    int  burst_left  = 0;
    bit  no_gaps     = 1'b0;
    bit  hold_req    = 1'b0;
    int  quiet_cycles;

    int  phase_len [N_PHASES] = '{1, 2, 16, 3, 4, 8, 15, 0, 5, 31, 7, 12, 16, 9, 17, 6};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic sbpt_pkg::result_t next_trigger_result(
        logic [sbpt_pkg::OP_W-1:0] op, logic [7:0] rx);
        sbpt_pkg::result_t r;
        int                eff;
        bit                hit;
        logic [127:0]      pat;
        eff = (pat_len_m > sbpt_pkg::LEN_W'(sbpt_pkg::PAT_BYTES))
            ? sbpt_pkg::PAT_BYTES : int'(pat_len_m);
        pat = {pat_high_m, pat_low_m};
        hit = 1'b0;
        if (op == sbpt_pkg::OP_BYTE) begin
            // the window only moves while armed
            if (armed_m) begin
                for (int i = sbpt_pkg::PAT_BYTES - 1; i > 0; i--) win_m[i] = win_m[i-1];
                win_m[0] = rx;
                hit = (eff != 0);
                for (int k = 0; k < eff; k++) begin
                    if (win_m[eff-1-k] != pat[k*8 +: 8]) hit = 1'b0;
                end
                if (hit) armed_m = 1'b0;
            end
        end else if (op == sbpt_pkg::OP_ARM) begin
            if (eff != 0) armed_m = 1'b1;
        end else if (op == sbpt_pkg::OP_DISARM) begin
            armed_m = 1'b0;
        end
        r.trigger = hit;
        r.armed   = armed_m;
        return r;
    endfunction

    function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
        end
    endfunction

    // scoreboard: results first, then register writes, then new items
    always @(posedge aclk) begin
        trig_expect_t e;
        typed_note_t  note;
        if (!aresetn) begin
            win_m      = '{default: '0};
            armed_m    = 1'b0;
            pat_low_m  = '0;
            pat_high_m = '0;
            pat_len_m  = '0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result %0h", $time, m_tdata);
                end else begin
                    e = pending_results.pop_front();
                    check_field("trigger", 8'(e.predicted.trigger), 8'(m_tdata[0]));
                    check_field("armed", 8'(e.predicted.armed), 8'(m_tdata[1]));
                    check_field("padding", 8'h00, 8'(m_tdata[7:2]));
                    if (e.chk) begin
                        check_field("table trigger", 8'(e.typed.trigger), 8'(m_tdata[0]));
                        check_field("table armed", 8'(e.typed.armed), 8'(m_tdata[1]));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                n_writes++;
                case (cfg_index)
                    sbpt_pkg::CFG_PAT_LOW: begin
                        pat_low_m = cfg_data;
                        win_m     = '{default: '0};
                    end
                    sbpt_pkg::CFG_PAT_HIGH: begin
                        pat_high_m = cfg_data;
                        win_m      = '{default: '0};
                    end
                    sbpt_pkg::CFG_PAT_LEN: begin
                        pat_len_m = cfg_data[sbpt_pkg::LEN_W-1:0];
                        win_m     = '{default: '0};
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                note        = typed_notes.pop_front();
                e.predicted = next_trigger_result(s_tuser, s_tdata);
                e.chk       = note.chk;
                e.typed     = note.typed;
                pending_results.push_back(e);
                n_items++;
                if (e.predicted.trigger) n_triggers++;
            end
        end
    end

    // receiver: segments of always-ready, coin-flip and mostly-stalled
    initial begin : rx_pace
        int seg_left;
        int seg_mode;
        seg_left = 0;
        seg_mode = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (seg_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_byte(bit narrow);
        if (!narrow) return 8'($urandom);
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h55;
            default: return 8'hAA;
        endcase
    endfunction

    function automatic void add_item(logic [sbpt_pkg::OP_W-1:0] op, logic [7:0] rx, bit chk,
                                     logic t, logic a);
        stim_row_t row;
        row.kind          = ROW_ITEM;
        row.op            = op;
        row.idx           = '0;
        row.val           = sbpt_pkg::CFG_DATA_W'(rx);
        row.chk           = chk;
        row.typed.trigger = t;
        row.typed.armed   = a;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_reg(logic [sbpt_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sbpt_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind  = ROW_REG;
        row.op    = sbpt_pkg::OP_BYTE;
        row.idx   = idx;
        row.val   = val;
        row.chk   = 1'b0;
        row.typed = '0;
        stim_rows.push_back(row);
    endfunction

    // sender paced in bursts; the note says whether a table value is checked too
    task automatic send_item(input logic [sbpt_pkg::OP_W-1:0] op, input logic [7:0] rx,
                             input bit chk, input sbpt_pkg::result_t typed);
        typed_note_t note;
        int          gap;
        if (burst_left <= 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        note.chk   = chk;
        note.typed = typed;
        typed_notes.push_back(note);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic flush_reg_writes();
        while (reg_writes.size() != 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_writes[0].idx;
            cfg_data  <= reg_writes[0].data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            reg_writes.delete(0);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : main_seq
        logic [127:0]                    pat;
        logic [sbpt_pkg::CFG_DATA_W-1:0] noise;
        logic [7:0]                      rx;
        sbpt_pkg::result_t               none;
        reg_write_t                      w;
        bit                              narrow;
        int                              eff;
        int                              n_feed;
        int                              pick;
        int                              sent;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        none      = '0;

        // reset state, nothing programmed
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 0, 0);
        add_item(sbpt_pkg::OP_ARM,    8'h00, 1, 0, 0);
        add_item(sbpt_pkg::OP_DISARM, 8'hA5, 1, 0, 0);
        add_item(OP_RESERVED,         8'h5A, 1, 0, 0);
        // three-byte pattern A5 00 FF
        add_reg(sbpt_pkg::CFG_PAT_LOW,  64'h0123_4567_89FF_00A5);
        add_reg(sbpt_pkg::CFG_PAT_HIGH, 64'hFEDC_BA98_7654_3210);
        add_reg(sbpt_pkg::CFG_PAT_LEN,  64'd3);
        add_item(sbpt_pkg::OP_ARM,    8'h00, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'hA5, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'h00, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 1, 0);
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 0, 0);
        add_item(sbpt_pkg::OP_ARM,    8'hFF, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'hA5, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'h00, 1, 0, 1);
        // unused index must neither store nor clear the window
        add_reg(CFG_UNUSED,           '1);
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 1, 0);
        add_item(sbpt_pkg::OP_ARM,    8'h00, 1, 0, 1);
        add_item(sbpt_pkg::OP_DISARM, 8'h00, 1, 0, 0);
        add_item(sbpt_pkg::OP_ARM,    8'h00, 1, 0, 1);
        add_item(OP_RESERVED,         8'hFF, 1, 0, 1);
        // empty pattern while armed; upper data bits are dropped
        add_reg(sbpt_pkg::CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFE0);
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 0, 1);
        add_item(sbpt_pkg::OP_ARM,    8'hFF, 1, 0, 1);
        // length clamps to sixteen, cleared window equals an all-zero pattern
        add_reg(sbpt_pkg::CFG_PAT_LOW,  '0);
        add_reg(sbpt_pkg::CFG_PAT_HIGH, '0);
        add_reg(sbpt_pkg::CFG_PAT_LEN,  64'd31);
        add_item(sbpt_pkg::OP_BYTE,   8'h00, 1, 1, 0);
        // sixteen bytes, newest byte taken from the top of the high word
        add_reg(sbpt_pkg::CFG_PAT_HIGH, 64'hFF00_0000_0000_0000);
        add_reg(sbpt_pkg::CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFF0);
        add_item(sbpt_pkg::OP_ARM,    8'h00, 1, 0, 1);
        add_item(sbpt_pkg::OP_BYTE,   8'hFF, 1, 1, 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < stim_rows.size(); r++) begin
            if (stim_rows[r].kind == ROW_REG) begin
                if (reg_writes.size() == 0) drain();
                w.idx  = stim_rows[r].idx;
                w.data = stim_rows[r].val;
                reg_writes.push_back(w);
                if (r + 1 == stim_rows.size() || stim_rows[r+1].kind != ROW_REG)
                    flush_reg_writes();
            end else begin
                send_item(stim_rows[r].op, stim_rows[r].val[7:0], stim_rows[r].chk,
                          stim_rows[r].typed);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            pick   = $urandom_range(0, 4);
            narrow = (pick <= 2);
            case (pick)
                0: pat = '0;
                1: pat = '1;
                2: begin
                    for (int k = 0; k < sbpt_pkg::PAT_BYTES; k++)
                        pat[k*8 +: 8] = pick_byte(1'b1);
                end
                default: pat = {$urandom, $urandom, $urandom, $urandom};
            endcase
            eff = (phase_len[ph] > sbpt_pkg::PAT_BYTES) ? sbpt_pkg::PAT_BYTES
                                                        : phase_len[ph];

            drain();
            w.idx  = sbpt_pkg::CFG_PAT_LOW;
            w.data = pat[63:0];
            reg_writes.push_back(w);
            w.idx  = sbpt_pkg::CFG_PAT_HIGH;
            w.data = pat[127:64];
            reg_writes.push_back(w);
            if (ph == 0 || $urandom_range(0, 3) == 0) begin
                w.idx  = CFG_UNUSED;
                w.data = {$urandom, $urandom};
                reg_writes.push_back(w);
            end
            noise  = {$urandom, $urandom};
            w.idx  = sbpt_pkg::CFG_PAT_LEN;
            w.data = {noise[sbpt_pkg::CFG_DATA_W-1:sbpt_pkg::LEN_W],
                      sbpt_pkg::LEN_W'(phase_len[ph])};
            reg_writes.push_back(w);
            flush_reg_writes();

            // one phase runs flat out against a long receiver hold-off
            no_gaps = (ph == 2);
            if (ph == 2) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    if ($urandom_range(0, 3) != 0) begin
                        send_item(sbpt_pkg::OP_ARM, 8'($urandom), 1'b0, none);
                        sent++;
                    end
                    n_feed = eff;
                    if ($urandom_range(0, 4) == 0) n_feed = $urandom_range(0, eff);
                    for (int k = 0; k < n_feed; k++) begin
                        rx = pat[k*8 +: 8];
                        if ($urandom_range(0, 24) == 0) rx = 8'($urandom);
                        send_item(sbpt_pkg::OP_BYTE, rx, 1'b0, none);
                        sent++;
                    end
                end else if (pick < 75) begin
                    send_item(sbpt_pkg::OP_BYTE,
                              pick_byte(narrow && $urandom_range(0, 1) == 1),
                              1'b0, none);
                    sent++;
                end else if (pick < 85) begin
                    send_item(sbpt_pkg::OP_ARM, 8'($urandom), 1'b0, none);
                    sent++;
                end else if (pick < 92) begin
                    send_item(sbpt_pkg::OP_DISARM, 8'($urandom), 1'b0, none);
                    sent++;
                end else if (pick < 96) begin
                    send_item(OP_RESERVED, 8'($urandom), 1'b0, none);
                    sent++;
                end else begin
                    // sender waits for every outstanding result
                    drain();
                end
            end
        end
        no_gaps = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("tb: %0d items checked, %0d triggers, %0d register writes",
                 n_items, n_triggers, n_writes);
        $display("tb: %0d pattern phases, lengths 0 to 31, one long receiver hold-off",
                 N_PHASES);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
